FILE: hdl/timer_event_heap_scheduler_assert.svh
// Assertion macros shared by the scheduler RTL.
`ifndef TIMER_EVENT_HEAP_SCHEDULER_ASSERT_SVH
`define TIMER_EVENT_HEAP_SCHEDULER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define HES_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define HES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/hes_pkg.sv
package hes_pkg;

    localparam int TIME_W       = 48;
    localparam int RESULT_LIMIT = 64;
    localparam int FIRE_AW      = 6;
    localparam int NFIRED_W     = 7;

    typedef enum logic [2:0] {
        M_DEFINE    = 3'd0,
        M_SCHED_IVL = 3'd1,
        M_SCHED_ABS = 3'd2,
        M_RESCHED   = 3'd3,
        M_UNSCHED   = 3'd4,
        M_SET_PRIO  = 3'd5,
        M_SET_IVL   = 3'd6,
        M_RUN       = 3'd7
    } hes_mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PRIO_RD,
        S_DROP,
        S_DROP_RD,
        S_ADD,
        S_UP,
        S_UP_CMP,
        S_DOWN,
        S_DOWN_L,
        S_DOWN_R,
        S_DOWN_CMP,
        S_PLACE,
        S_RUN_CHK,
        S_RUN_HEAD,
        S_FINISH
    } hes_state_t;

    typedef enum logic [1:0] {
        P_HEAD,
        P_EMIT,
        P_NONE
    } hes_phase_t;

    typedef struct packed {
        hes_mode_t   mode;
        logic [5:0]  event_id;
        logic [47:0] time_value;
        logic [31:0] interval_value;
        logic        oneshot_flag;
        logic [7:0]  priority_value;
        logic [47:0] now_ms;
    } hes_cmd_t;

    typedef struct packed {
        logic        status;
        logic        fired_valid;
        logic [5:0]  fired_event;
        logic        last_result;
        logic [47:0] head_fire_time;
        logic [6:0]  scheduled_count;
    } hes_res_t;

    // Heap ordering key
    typedef struct packed {
        logic [47:0] fire_time;
        logic [7:0]  prio;
    } hes_key_t;

    // Per-event settings
    typedef struct packed {
        logic [31:0] interval;
        logic        oneshot;
        logic [7:0]  prio;
    } hes_cfg_t;

    // Saturating 48-bit time sum
    function automatic logic [47:0] hes_sat_add(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? {TIME_W{1'b1}} : s[47:0];
    endfunction

endpackage

FILE: hdl/hes_cmp.sv
// Heap order compare: earlier fire time first, higher priority on ties.
module hes_cmp
    import hes_pkg::*;
(
    input  hes_key_t a,
    input  hes_key_t b,
    output logic     a_first
);

    always_comb
    begin
        if (a.fire_time != b.fire_time)
        begin
            a_first = a.fire_time < b.fire_time;
        end
        else
        begin
            a_first = a.prio > b.prio;
        end
    end

endmodule

FILE: hdl/timer_event_heap_scheduler.sv
// Channel   | Ports                         | Transaction
// ----------+-------------------------------+------------------------------------------
// command   | start, busy, cmd              | taken at an edge with start high, busy low
// result    | result_valid, result          | one cycle per result, cannot be held off
//
// Steps: a rejected command goes straight to its result; a heap remove refills the slot from
// the last entry and sifts it up or else down, level by level; an insert appends and sifts up.
// A run checks the head and does a remove, and for a periodic event a re-insert, per fired event,
// then emits its results back to back, one per cycle, at the end.
// Reset clears the defined and scheduled flags and the heap count; no clearing pass.
// busy drops in the cycle that shows the last result; the next command can go at its end.
`include "timer_event_heap_scheduler_assert.svh"

module timer_event_heap_scheduler
    import hes_pkg::*;
#(
    parameter int EVENT_COUNT = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  hes_cmd_t cmd,
    output logic     result_valid,
    output hes_res_t result
);

    localparam int IW = (EVENT_COUNT > 1) ? $clog2(EVENT_COUNT) : 1;
    localparam int CW = $clog2(EVENT_COUNT + 1);

    // Control and working registers
    hes_state_t            state_reg, state_next;
    hes_mode_t             mode_reg, mode_next;
    logic [IW-1:0]         id_reg, id_next;
    logic                  ok_reg, ok_next;
    logic [47:0]           tval_reg, tval_next;
    logic [31:0]           ival_reg, ival_next;
    logic                  oneshot_reg, oneshot_next;
    logic [7:0]            prio_reg, prio_next;
    logic [47:0]           now_reg, now_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [IW-1:0]         hole_reg, hole_next;
    logic [IW-1:0]         drop_i_reg, drop_i_next;
    logic [IW-1:0]         tgt_reg, tgt_next;
    hes_key_t              cur_key_reg, cur_key_next;
    logic [IW-1:0]         cur_id_reg, cur_id_next;
    hes_key_t              child_key_reg, child_key_next;
    logic [IW-1:0]         child_id_reg, child_id_next;
    logic [IW-1:0]         child_idx_reg, child_idx_next;
    hes_key_t              new_key_reg, new_key_next;
    logic                  add_pend_reg, add_pend_next;
    logic                  from_drop_reg, from_drop_next;
    logic [NFIRED_W-1:0]   nfired_reg, nfired_next;
    logic [FIRE_AW-1:0]    emit_idx_reg, emit_idx_next;
    logic                  status_reg, status_next;
    logic                  emitting_reg, emitting_next;
    logic [EVENT_COUNT-1:0] defined_reg, defined_next;
    logic [EVENT_COUNT-1:0] in_heap_reg, in_heap_next;
    hes_res_t              res_reg, res_next;
    logic                  res_valid_reg, res_valid_next;

    // Memories
    hes_cfg_t              cfg_mem   [EVENT_COUNT];
    logic [IW-1:0]         slot_mem  [EVENT_COUNT];
    hes_key_t              hkey_mem  [EVENT_COUNT];
    logic [IW-1:0]         hid_mem   [EVENT_COUNT];
    logic [5:0]            fire_mem  [RESULT_LIMIT];

    hes_cfg_t              cfg_rd;
    logic [IW-1:0]         slot_rd;
    hes_key_t              hk_rd;
    logic [IW-1:0]         hid_rd;
    logic [5:0]            fire_rd;

    logic [IW-1:0]         cfg_raddr, cfg_waddr;
    logic                  cfg_we;
    hes_cfg_t              cfg_wdata;
    logic                  slot_we;
    logic [IW-1:0]         slot_waddr, slot_wdata;
    logic [IW-1:0]         heap_raddr, heap_waddr;
    logic                  heap_we;
    hes_key_t              heap_wkey;
    logic [IW-1:0]         heap_wid;
    logic                  fire_we;
    logic [FIRE_AW-1:0]    fire_waddr, fire_raddr;
    logic [5:0]            fire_wdata;

    // Shared compare unit
    hes_key_t              cmp_a, cmp_b;
    logic                  cmp_first;

    hes_cmp u_cmp (
        .a       (cmp_a),
        .b       (cmp_b),
        .a_first (cmp_first)
    );

    logic [IW-1:0]         cmd_idx;
    logic                  def;
    logic [IW-1:0]         parent;
    logic [CW:0]           lw, rw, cnt_w;
    logic [IW-1:0]         last_slot;
    logic                  pend_now;
    hes_state_t            after_op;
    logic                  fired_any;
    logic                  last_now;

    assign cmd_idx   = IW'(cmd.event_id);
    assign def       = ok_reg && defined_reg[id_reg];
    assign parent    = IW'((hole_reg - IW'(1)) >> 1);
    assign lw        = (CW + 1)'({hole_reg, 1'b1});
    assign rw        = lw + (CW + 1)'(1);
    assign cnt_w     = (CW + 1)'(count_reg);
    assign last_slot = IW'(count_reg - CW'(1));
    assign busy      = (state_reg != S_IDLE);
    assign fired_any = (mode_reg == M_RUN) && (nfired_reg != '0);
    assign last_now  = !fired_any || (NFIRED_W'(emit_idx_reg) == nfired_reg - NFIRED_W'(1));

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // Memory ports
    always_ff @(posedge clk)
    begin
        if (cfg_we)
        begin
            cfg_mem[cfg_waddr] <= cfg_wdata;
        end
        cfg_rd <= cfg_mem[cfg_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rd <= slot_mem[cmd_idx];
    end

    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            hkey_mem[heap_waddr] <= heap_wkey;
            hid_mem[heap_waddr]  <= heap_wid;
        end
        hk_rd  <= hkey_mem[heap_raddr];
        hid_rd <= hid_mem[heap_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (fire_we)
        begin
            fire_mem[fire_waddr] <= fire_wdata;
        end
        fire_rd <= fire_mem[fire_raddr];
    end

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            defined_reg   <= '0;
            in_heap_reg   <= '0;
            add_pend_reg  <= 1'b0;
            from_drop_reg <= 1'b0;
            nfired_reg    <= '0;
            emit_idx_reg  <= '0;
            emitting_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            defined_reg   <= defined_next;
            in_heap_reg   <= in_heap_next;
            add_pend_reg  <= add_pend_next;
            from_drop_reg <= from_drop_next;
            nfired_reg    <= nfired_next;
            emit_idx_reg  <= emit_idx_next;
            emitting_reg  <= emitting_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        id_reg        <= id_next;
        ok_reg        <= ok_next;
        tval_reg      <= tval_next;
        ival_reg      <= ival_next;
        oneshot_reg   <= oneshot_next;
        prio_reg      <= prio_next;
        now_reg       <= now_next;
        hole_reg      <= hole_next;
        drop_i_reg    <= drop_i_next;
        tgt_reg       <= tgt_next;
        cur_key_reg   <= cur_key_next;
        cur_id_reg    <= cur_id_next;
        child_key_reg <= child_key_next;
        child_id_reg  <= child_id_next;
        child_idx_reg <= child_idx_next;
        new_key_reg   <= new_key_next;
        status_reg    <= status_next;
        res_reg       <= res_next;
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        id_next        = id_reg;
        ok_next        = ok_reg;
        tval_next      = tval_reg;
        ival_next      = ival_reg;
        oneshot_next   = oneshot_reg;
        prio_next      = prio_reg;
        now_next       = now_reg;
        count_next     = count_reg;
        hole_next      = hole_reg;
        drop_i_next    = drop_i_reg;
        tgt_next       = tgt_reg;
        cur_key_next   = cur_key_reg;
        cur_id_next    = cur_id_reg;
        child_key_next = child_key_reg;
        child_id_next  = child_id_reg;
        child_idx_next = child_idx_reg;
        new_key_next   = new_key_reg;
        add_pend_next  = add_pend_reg;
        from_drop_next = from_drop_reg;
        nfired_next    = nfired_reg;
        emit_idx_next  = emit_idx_reg;
        emitting_next  = emitting_reg;
        status_next    = status_reg;
        defined_next   = defined_reg;
        in_heap_next   = in_heap_reg;
        res_next       = res_reg;
        res_valid_next = 1'b0;

        cfg_raddr  = (state_reg == S_IDLE) ? cmd_idx : hid_rd;
        cfg_we     = 1'b0;
        cfg_waddr  = id_reg;
        cfg_wdata  = cfg_rd;
        slot_we    = 1'b0;
        slot_waddr = cur_id_reg;
        slot_wdata = hole_reg;
        heap_raddr = '0;
        heap_we    = 1'b0;
        heap_waddr = hole_reg;
        heap_wkey  = cur_key_reg;
        heap_wid   = cur_id_reg;
        fire_we    = 1'b0;
        fire_waddr = nfired_reg[FIRE_AW-1:0];
        fire_wdata = 6'(hid_rd);
        fire_raddr = '0;
        cmp_a      = cur_key_reg;
        cmp_b      = hk_rd;

        pend_now = add_pend_reg;
        after_op = (mode_reg == M_RUN) ? S_RUN_CHK : S_FINISH;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next     = cmd.mode;
                    id_next       = cmd_idx;
                    ok_next       = (32'(cmd.event_id) < EVENT_COUNT);
                    tval_next     = cmd.time_value;
                    ival_next     = cmd.interval_value;
                    oneshot_next  = cmd.oneshot_flag;
                    prio_next     = cmd.priority_value;
                    now_next      = cmd.now_ms;
                    status_next   = 1'b0;
                    add_pend_next = 1'b0;
                    nfired_next   = '0;
                    emitting_next = 1'b0;
                    state_next    = S_DECODE;
                end
            end

            S_DECODE:
            begin
                tgt_next    = id_reg;
                drop_i_next = slot_rd;
                unique case (mode_reg)
                    M_DEFINE:
                    begin
                        if (!ok_reg || ival_reg == '0)
                        begin
                            status_next = 1'b1;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            cfg_we               = 1'b1;
                            cfg_wdata            = '{ival_reg, oneshot_reg, prio_reg};
                            defined_next[id_reg] = 1'b1;
                            state_next           = S_DROP;
                        end
                    end
                    M_SCHED_IVL, M_SCHED_ABS, M_RESCHED:
                    begin
                        if (!def || (mode_reg == M_RESCHED && tval_reg == '0))
                        begin
                            status_next = 1'b1;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            if (mode_reg == M_SCHED_IVL)
                            begin
                                new_key_next.fire_time =
                                    hes_sat_add(now_reg, 48'(cfg_rd.interval));
                            end
                            else if (mode_reg == M_SCHED_ABS)
                            begin
                                new_key_next.fire_time = tval_reg;
                            end
                            else
                            begin
                                new_key_next.fire_time = hes_sat_add(now_reg, tval_reg);
                            end
                            new_key_next.prio = cfg_rd.prio;
                            add_pend_next     = 1'b1;
                            state_next        = S_DROP;
                        end
                    end
                    M_UNSCHED:
                    begin
                        if (!def)
                        begin
                            status_next = 1'b1;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_DROP;
                        end
                    end
                    M_SET_PRIO:
                    begin
                        if (!def)
                        begin
                            status_next = 1'b1;
                            state_next  = S_FINISH;
                        end
                        else if (cfg_rd.prio != prio_reg)
                        begin
                            cfg_we    = 1'b1;
                            cfg_wdata = '{cfg_rd.interval, cfg_rd.oneshot, prio_reg};
                            if (in_heap_reg[id_reg])
                            begin
                                heap_raddr = slot_rd;
                                state_next = S_PRIO_RD;
                            end
                            else
                            begin
                                state_next = S_FINISH;
                            end
                        end
                        else
                        begin
                            state_next = S_FINISH;
                        end
                    end
                    M_SET_IVL:
                    begin
                        if (!def || ival_reg == '0)
                        begin
                            status_next = 1'b1;
                        end
                        else
                        begin
                            cfg_we    = 1'b1;
                            cfg_wdata = '{ival_reg, cfg_rd.oneshot, cfg_rd.prio};
                        end
                        state_next = S_FINISH;
                    end
                    M_RUN:
                    begin
                        state_next = S_RUN_CHK;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            // Re-sort at the old fire time with the new priority
            S_PRIO_RD:
            begin
                new_key_next  = '{hk_rd.fire_time, prio_reg};
                add_pend_next = 1'b1;
                state_next    = S_DROP;
            end

            // Remove tgt from the heap, filling its slot from the last one
            S_DROP:
            begin
                if (mode_reg == M_RUN)
                begin
                    pend_now     = !cfg_rd.oneshot;
                    new_key_next = '{hes_sat_add(now_reg, 48'(cfg_rd.interval)), cfg_rd.prio};
                end
                add_pend_next = pend_now;
                if (!in_heap_reg[tgt_reg])
                begin
                    state_next = pend_now ? S_ADD : after_op;
                end
                else
                begin
                    in_heap_next[tgt_reg] = 1'b0;
                    count_next            = count_reg - CW'(1);
                    if (drop_i_reg == last_slot)
                    begin
                        state_next = pend_now ? S_ADD : after_op;
                    end
                    else
                    begin
                        heap_raddr = last_slot;
                        state_next = S_DROP_RD;
                    end
                end
            end

            S_DROP_RD:
            begin
                cur_key_next   = hk_rd;
                cur_id_next    = hid_rd;
                hole_next      = drop_i_reg;
                from_drop_next = 1'b1;
                state_next     = S_UP;
            end

            // Append at the end of the heap
            S_ADD:
            begin
                cur_key_next          = new_key_reg;
                cur_id_next           = tgt_reg;
                hole_next             = IW'(count_reg);
                count_next            = count_reg + CW'(1);
                in_heap_next[tgt_reg] = 1'b1;
                add_pend_next         = 1'b0;
                from_drop_next        = 1'b0;
                state_next            = S_UP;
            end

            S_UP:
            begin
                if (hole_reg == '0)
                begin
                    state_next = from_drop_reg ? S_DOWN : S_PLACE;
                end
                else
                begin
                    heap_raddr = parent;
                    state_next = S_UP_CMP;
                end
            end

            // Parent moves down into the hole when cur goes first
            S_UP_CMP:
            begin
                if (cmp_first)
                begin
                    heap_we        = 1'b1;
                    heap_wkey      = hk_rd;
                    heap_wid       = hid_rd;
                    slot_we        = 1'b1;
                    slot_waddr     = hid_rd;
                    hole_next      = parent;
                    from_drop_next = 1'b0;
                    state_next     = S_UP;
                end
                else
                begin
                    state_next = from_drop_reg ? S_DOWN : S_PLACE;
                end
            end

            S_DOWN:
            begin
                if (lw >= cnt_w)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    heap_raddr = IW'(lw);
                    state_next = S_DOWN_L;
                end
            end

            S_DOWN_L:
            begin
                child_key_next = hk_rd;
                child_id_next  = hid_rd;
                child_idx_next = IW'(lw);
                if (rw < cnt_w)
                begin
                    heap_raddr = IW'(rw);
                    state_next = S_DOWN_R;
                end
                else
                begin
                    state_next = S_DOWN_CMP;
                end
            end

            // Pick the better child
            S_DOWN_R:
            begin
                cmp_a = hk_rd;
                cmp_b = child_key_reg;
                if (cmp_first)
                begin
                    child_key_next = hk_rd;
                    child_id_next  = hid_rd;
                    child_idx_next = IW'(rw);
                end
                state_next = S_DOWN_CMP;
            end

            // Child moves up into the hole when it goes before cur
            S_DOWN_CMP:
            begin
                cmp_a = child_key_reg;
                cmp_b = cur_key_reg;
                if (cmp_first)
                begin
                    heap_we    = 1'b1;
                    heap_wkey  = child_key_reg;
                    heap_wid   = child_id_reg;
                    slot_we    = 1'b1;
                    slot_waddr = child_id_reg;
                    hole_next  = child_idx_reg;
                    state_next = S_DOWN;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end

            S_PLACE:
            begin
                heap_we    = 1'b1;
                slot_we    = 1'b1;
                state_next = add_pend_reg ? S_ADD : after_op;
            end

            S_RUN_CHK:
            begin
                if (count_reg == '0 || nfired_reg == NFIRED_W'(RESULT_LIMIT))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_RUN_HEAD;
                end
            end

            // Head due: log it and pop it; cfg of the head is read meanwhile
            S_RUN_HEAD:
            begin
                if (hk_rd.fire_time > now_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    fire_we     = 1'b1;
                    nfired_next = nfired_reg + NFIRED_W'(1);
                    tgt_next    = hid_rd;
                    drop_i_next = '0;
                    state_next  = S_DROP;
                end
            end

            // Fetch the head, then emit results one per cycle
            S_FINISH:
            begin
                if (!emitting_reg)
                begin
                    emitting_next = 1'b1;
                    emit_idx_next = '0;
                end
                else
                begin
                    res_valid_next           = 1'b1;
                    res_next.status          = status_reg;
                    res_next.fired_valid     = fired_any;
                    res_next.fired_event     = fired_any ? fire_rd : 6'd0;
                    res_next.last_result     = last_now;
                    res_next.head_fire_time  =
                        (count_reg == '0) ? {TIME_W{1'b1}} : hk_rd.fire_time;
                    res_next.scheduled_count = 7'(count_reg);
                    fire_raddr               = emit_idx_reg + FIRE_AW'(1);
                    emit_idx_next            = emit_idx_reg + FIRE_AW'(1);
                    if (last_now)
                    begin
                        emitting_next = 1'b0;
                        state_next    = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Head fetch is issued ahead of the emit phase
        if (state_reg == S_RUN_CHK || (state_reg == S_FINISH && !emitting_reg))
        begin
            heap_raddr = '0;
        end
    end

    // Checks
    `HES_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CW'(EVENT_COUNT),
        "heap count above table size")
    `HES_ASSERT_SAME(a_count_match, state_reg == S_IDLE,
        $countones(in_heap_reg) == 32'(count_reg), "scheduled flags disagree with heap count")
    `HES_ASSERT_NEXT(a_burst, res_valid_reg && !res_reg.last_result, res_valid_reg,
        "gap inside a result burst")
    `HES_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "command taken without going busy")
    `HES_ASSERT_SAME(a_fired_ok, res_valid_reg && res_reg.fired_valid, !res_reg.status,
        "fired result with error status")

endmodule

FILE: tb/timer_event_heap_scheduler_checker.sv
// Watches the command and result channels of the timer heap scheduler,
// keeps its own copy of the event table and heap, and checks every result.
module timer_event_heap_scheduler_checker
    import hes_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  hes_cmd_t cmd,
    input  logic     result_valid,
    input  hes_res_t result,
    output int       fail_count,
    output int       pending
);

    localparam logic [47:0] TMAX = {TIME_W{1'b1}};

    // shadow event table and heap
    bit          ev_def   [64];
    logic [31:0] ev_ivl   [64];
    bit          ev_one   [64];
    logic [7:0]  ev_prio  [64];
    logic [47:0] ev_time  [64];
    bit          ev_sched [64];
    int          ev_slot  [64];
    int          heap     [64];
    int          heap_n;

    hes_res_t    expected_q[$];

    initial
    begin
        fail_count = 0;
        heap_n     = 0;
        for (int i = 0; i < 64; i++)
        begin
            ev_def[i]   = 0;
            ev_sched[i] = 0;
        end
    end

    assign pending = expected_q.size();

    function automatic logic [47:0] time_sum(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? TMAX : s[47:0];
    endfunction

    // ordering: earlier fire time, then higher priority
    function automatic bit earlier(input int a, input int b);
        if (ev_time[a] != ev_time[b])
            return ev_time[a] < ev_time[b];
        return ev_prio[a] > ev_prio[b];
    endfunction

    function automatic void swap_slots(input int i, input int j);
        int ei;
        int ej;
        ei = heap[i];
        ej = heap[j];
        heap[i] = ej;
        heap[j] = ei;
        ev_slot[ei] = j;
        ev_slot[ej] = i;
    endfunction

    function automatic void sift_up(input int i);
        int p;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (!earlier(heap[i], heap[p]))
                break;
            swap_slots(i, p);
            i = p;
        end
    endfunction

    function automatic void sift_down(input int i);
        int l;
        int r;
        int best;
        forever
        begin
            l = 2 * i + 1;
            r = 2 * i + 2;
            best = i;
            if (l < heap_n && earlier(heap[l], heap[best]))
                best = l;
            if (r < heap_n && earlier(heap[r], heap[best]))
                best = r;
            if (best == i)
                break;
            swap_slots(i, best);
            i = best;
        end
    endfunction

    function automatic void heap_insert(input int e);
        if (ev_sched[e] || heap_n >= 64)
            return;
        heap[heap_n] = e;
        ev_slot[e]   = heap_n;
        ev_sched[e]  = 1;
        heap_n++;
        sift_up(heap_n - 1);
    endfunction

    function automatic void heap_remove(input int e);
        int i;
        int last;
        if (!ev_sched[e] || heap_n == 0)
            return;
        i = ev_slot[e];
        last = heap_n - 1;
        if (i < last)
            swap_slots(i, last);
        heap_n--;
        if (i < heap_n)
        begin
            if (i > 0 && earlier(heap[i], heap[(i - 1) / 2]))
                sift_up(i);
            else
                sift_down(i);
        end
        ev_sched[e] = 0;
    endfunction

    function automatic void place_event(input int e, input logic [47:0] t);
        ev_time[e] = t;
        heap_remove(e);
        heap_insert(e);
    endfunction

    // apply one command, queue the results it should produce
    function automatic void predict_results(input hes_cmd_t c);
        hes_res_t  r;
        hes_res_t  batch[$];
        int        id;
        int        e;
        bit        def;
        logic      st;
        id  = c.event_id;
        def = ev_def[id];
        st  = 1'b0;
        r   = '0;
        if (c.mode == M_RUN)
        begin
            while (heap_n > 0 && batch.size() < RESULT_LIMIT)
            begin
                e = heap[0];
                if (ev_time[e] > c.now_ms)
                    break;
                heap_remove(e);
                if (!ev_one[e])
                    place_event(e, time_sum(c.now_ms, {16'd0, ev_ivl[e]}));
                r = '0;
                r.fired_valid = 1'b1;
                r.fired_event = e[5:0];
                batch.push_back(r);
            end
            if (batch.size() == 0)
                batch.push_back('0);
        end
        else
        begin
            case (c.mode)
                M_DEFINE:
                    if (c.interval_value == 0)
                        st = 1'b1;
                    else
                    begin
                        heap_remove(id);
                        ev_def[id]  = 1;
                        ev_ivl[id]  = c.interval_value;
                        ev_one[id]  = c.oneshot_flag;
                        ev_prio[id] = c.priority_value;
                    end
                M_SCHED_IVL:
                    if (!def)
                        st = 1'b1;
                    else
                        place_event(id, time_sum(c.now_ms, {16'd0, ev_ivl[id]}));
                M_SCHED_ABS:
                    if (!def)
                        st = 1'b1;
                    else
                        place_event(id, c.time_value);
                M_RESCHED:
                    if (!def || c.time_value == 0)
                        st = 1'b1;
                    else
                        place_event(id, time_sum(c.now_ms, c.time_value));
                M_UNSCHED:
                    if (!def)
                        st = 1'b1;
                    else
                        heap_remove(id);
                M_SET_PRIO:
                    if (!def)
                        st = 1'b1;
                    else if (ev_prio[id] != c.priority_value)
                    begin
                        ev_prio[id] = c.priority_value;
                        if (ev_sched[id])
                            place_event(id, ev_time[id]);
                    end
                default:
                    if (!def || c.interval_value == 0)
                        st = 1'b1;
                    else
                        ev_ivl[id] = c.interval_value;
            endcase
            r = '0;
            r.status = st;
            batch.push_back(r);
        end
        // head and count reflect the state after the whole step
        foreach (batch[k])
        begin
            batch[k].last_result     = (k == batch.size() - 1);
            batch[k].head_fire_time  = heap_n > 0 ? ev_time[heap[0]] : TMAX;
            batch[k].scheduled_count = heap_n[6:0];
            expected_q.push_back(batch[k]);
        end
    endfunction

    // results first, then new transaction, so an edge carrying both stays in order
    always @(posedge clk)
    begin
        hes_res_t exp_r;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result %h", $realtime, result);
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (result.status !== exp_r.status
                        || result.fired_valid !== exp_r.fired_valid
                        || result.fired_event !== exp_r.fired_event
                        || result.last_result !== exp_r.last_result
                        || result.head_fire_time !== exp_r.head_fire_time
                        || result.scheduled_count !== exp_r.scheduled_count)
                    begin
                        fail_count++;
                        $display("%0t: mismatch expected st=%b fv=%b ev=%0d last=%b head=%h cnt=%0d",
                                 $realtime, exp_r.status, exp_r.fired_valid, exp_r.fired_event,
                                 exp_r.last_result, exp_r.head_fire_time, exp_r.scheduled_count);
                        $display("%0t:          actual   st=%b fv=%b ev=%0d last=%b head=%h cnt=%0d",
                                 $realtime, result.status, result.fired_valid, result.fired_event,
                                 result.last_result, result.head_fire_time,
                                 result.scheduled_count);
                    end
                end
            end
            if (start && !busy)
                predict_results(cmd);
        end
    end

endmodule

FILE: tb/tb_timer_event_heap_scheduler.sv
module tb_timer_event_heap_scheduler;
    import hes_pkg::*;

    localparam int CYCLE_LIMIT = 10000000;
    localparam logic [47:0] TMAX = {TIME_W{1'b1}};

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    hes_cmd_t cmd;
    logic     result_valid;
    hes_res_t result;
    int       fail_count;
    int       pending;
    int       cycles;
    logic [47:0] now_t;

    timer_event_heap_scheduler u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result)
    );

    timer_event_heap_scheduler_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("tb_timer_event_heap_scheduler: errors");
                $finish;
            end
        end
    end

    function automatic logic [47:0] rand48();
        return {16'($urandom()), $urandom()};
    endfunction

    // issue one transaction; start stays high when the next follows at once
    task automatic issue(input hes_mode_t m, input int id, input logic [47:0] tv,
                         input logic [31:0] iv, input bit one, input logic [7:0] pr,
                         input logic [47:0] now);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start                <= 1'b1;
        cmd.mode             <= m;
        cmd.event_id         <= id[5:0];
        cmd.time_value       <= tv;
        cmd.interval_value   <= iv;
        cmd.oneshot_flag     <= one;
        cmd.priority_value   <= pr;
        cmd.now_ms           <= now;
        forever
        begin
            @(negedge clk);
            if (!busy)
                break;
        end
        @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (pending == 0)
                break;
        end
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        hes_mode_t m;
        int        id;
        int        pick;
        logic [47:0] tv;
        logic [31:0] iv;
        rst_n = 1'b0;
        start = 1'b0;
        cmd   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: errors, ties, saturation, run limit
        issue(M_SCHED_IVL, 40, 0, 0, 0, 0, 0);               // undefined event
        issue(M_DEFINE, 0, 0, 10, 0, 5, 0);
        issue(M_DEFINE, 1, 0, 25, 1, 200, 0);
        issue(M_DEFINE, 2, 0, 0, 0, 9, 0);                   // zero interval
        issue(M_SCHED_IVL, 0, 0, 0, 0, 0, 0);
        issue(M_SCHED_ABS, 1, 10, 0, 0, 0, 3);               // tie on time, prio wins
        issue(M_RESCHED, 0, 0, 0, 0, 0, 4);                  // zero delay
        issue(M_UNSCHED, 2, 0, 0, 0, 0, 4);                  // undefined
        issue(M_DEFINE, 2, 0, 3, 0, 0, 4);
        issue(M_UNSCHED, 2, 0, 0, 0, 0, 4);                  // not scheduled
        issue(M_SET_PRIO, 0, 0, 0, 0, 5, 5);                 // same priority
        issue(M_SET_PRIO, 0, 0, 0, 0, 255, 5);
        issue(M_SET_IVL, 2, 0, 0, 0, 0, 5);                  // zero interval
        issue(M_SET_IVL, 2, 0, 32'hFFFF_FFFF, 0, 0, 5);
        issue(M_RUN, 0, 0, 0, 0, 0, 5);                      // nothing due
        issue(M_RESCHED, 2, 48'h7, 0, 0, 0, 5);
        issue(M_RUN, 63, TMAX, 32'hFFFF_FFFF, 1, 255, 20);
        issue(M_DEFINE, 0, 0, 10, 0, 5, 20);                 // redefine while scheduled
        issue(M_DEFINE, 63, TMAX, 32'hFFFF_FFFF, 0, 255, 20);
        issue(M_RESCHED, 63, TMAX, 0, 0, 0, TMAX);           // saturating sum
        issue(M_SCHED_IVL, 2, 0, 0, 0, 0, TMAX);
        issue(M_RUN, 0, 0, 0, 0, 0, TMAX);                   // periodic at max hits limit
        issue(M_UNSCHED, 63, 0, 0, 0, 0, TMAX);
        issue(M_UNSCHED, 2, 0, 0, 0, 0, TMAX);
        issue(M_SCHED_ABS, 1, TMAX, 0, 0, 0, 0);

        // random: small id pool and small times so runs fire often
        now_t = 0;
        for (int n = 0; n < 300; n++)
        begin
            if (n == 150)
                drain();
            now_t = now_t + 48'($urandom_range(0, 12));
            pick = $urandom_range(0, 99);
            if (pick < 12)
                m = M_DEFINE;
            else if (pick < 30)
                m = M_SCHED_IVL;
            else if (pick < 40)
                m = M_SCHED_ABS;
            else if (pick < 48)
                m = M_RESCHED;
            else if (pick < 54)
                m = M_UNSCHED;
            else if (pick < 60)
                m = M_SET_PRIO;
            else if (pick < 65)
                m = M_SET_IVL;
            else
                m = M_RUN;
            id = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 11);
            pick = $urandom_range(0, 19);
            iv = (pick == 0) ? 32'd0 : (pick == 1) ? $urandom() : $urandom_range(1, 60);
            pick = $urandom_range(0, 19);
            if (m == M_SCHED_ABS)
                tv = (pick == 0) ? rand48() : now_t + 48'($urandom_range(0, 50));
            else
                tv = (pick == 0) ? 48'd0 : (pick == 1) ? rand48() : 48'($urandom_range(1, 60));
            issue(m, id, tv, iv, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0 ?
                  8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3)), now_t);
        end
        drain();

        if (fail_count == 0)
            $display("tb_timer_event_heap_scheduler: clean");
        else
            $display("tb_timer_event_heap_scheduler: errors");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/hes_pkg.sv
hdl/hes_cmp.sv
hdl/timer_event_heap_scheduler.sv
tb/timer_event_heap_scheduler_checker.sv
tb/tb_timer_event_heap_scheduler.sv
